// ===== hw/rtl/lbfit_pkg.sv =====
// lbfit_pkg: shared types and constants for the letterbox fit geometry block.
// Holds the request/response transaction structs and the dimension width.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lbfit_pkg;

   // dimension width of every size field
   localparam int unsigned DIM_W = 16;
   // offsets are at most half of a dimension
   localparam int unsigned PAD_W = DIM_W - 1;

   typedef struct packed {
      logic [DIM_W-1:0] src_w;
      logic [DIM_W-1:0] src_h;
      logic [DIM_W-1:0] dst_w;
      logic [DIM_W-1:0] dst_h;
   } req_type;

   typedef struct packed {
      logic [DIM_W-1:0] fit_w;
      logic [DIM_W-1:0] fit_h;
      logic [PAD_W-1:0] pad_x;
      logic [PAD_W-1:0] pad_y;
      logic             bad_size;
   } rsp_type;

endpackage : lbfit_pkg

`default_nettype wire

// ===== hw/rtl/letterbox_fit_geometry.sv =====
// Pipeline: an accepted request transaction reaches rsp_valid through one multiply
// stage, one select stage, DIM_W = 16 divide stages and one round/clamp/offset stage.
// Throughput: one transaction per cycle unless stalled; each stage has its own valid
// bit and advances when the stage after it is empty or moving, so bubbles collapse.
// Reset: synchronous, active high; clears all stage valid bits, payload is not reset.
// letterbox_fit_geometry: top level, aspect-preserving fit. Depends on lbfit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module letterbox_fit_geometry
   import lbfit_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   // request channel
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int unsigned PROD_W = 2 * DIM_W;

   // Stage 1: both cross products, registered straight after the multipliers.
   typedef struct packed {
      logic [PROD_W-1:0] wl;    // src_w * dst_h
      logic [PROD_W-1:0] hl;    // src_h * dst_w
      logic [DIM_W-1:0]  sw;
      logic [DIM_W-1:0]  sh;
      logic [DIM_W-1:0]  dw;
      logic [DIM_W-1:0]  dh;
      logic              bad;
   } mul_type;

   // Divide stages: restoring division, one quotient bit per stage.
   // wide = width is the limiting side, so the height is the scaled one.
   typedef struct packed {
      logic [DIM_W-1:0] rem;    // partial remainder, always below den
      logic [DIM_W-1:0] low;    // numerator bits not yet shifted in
      logic [DIM_W-1:0] quo;
      logic [DIM_W-1:0] den;
      logic [DIM_W-1:0] dw;
      logic [DIM_W-1:0] dh;
      logic             wide;
      logic             bad;
   } div_type;

   function automatic div_type div_step(input div_type cur);
      div_type          nxt;
      logic [DIM_W:0]   trial;
      nxt   = cur;
      trial = {cur.rem, cur.low[DIM_W-1]};
      nxt.low = {cur.low[DIM_W-2:0], 1'b0};
      if (trial >= {1'b0, cur.den}) begin
         trial   = trial - {1'b0, cur.den};
         nxt.quo = {cur.quo[DIM_W-2:0], 1'b1};
      end else begin
         nxt.quo = {cur.quo[DIM_W-2:0], 1'b0};
      end
      nxt.rem = trial[DIM_W-1:0];
      return nxt;
   endfunction

   //--------------------------------------------------------------------------
   // Pipeline registers
   //--------------------------------------------------------------------------
   logic    mul_vld_ff;
   mul_type mul_ff;
   logic    sel_vld_ff;
   div_type sel_ff;
   logic    div_vld_ff [DIM_W];
   div_type div_ff     [DIM_W];
   logic    rsp_vld_ff;
   rsp_type rsp_ff;

   mul_type mul_in;
   div_type sel_in;
   div_type div_in [DIM_W];
   rsp_type rsp_in;

   // per-stage "may load" flags; a stage loads when empty or when it moves on
   logic    out_rdy;
   logic    div_rdy [DIM_W];
   logic    sel_rdy;
   logic    mul_rdy;

   always_comb begin
      out_rdy = !rsp_vld_ff || !rsp_stall;
      div_rdy[DIM_W-1] = !div_vld_ff[DIM_W-1] || out_rdy;
      for (int d = DIM_W - 2; d >= 0; d--) begin
         div_rdy[d] = !div_vld_ff[d] || div_rdy[d+1];
      end
      sel_rdy = !sel_vld_ff || div_rdy[0];
      mul_rdy = !mul_vld_ff || sel_rdy;
   end

   assign req_stall = !mul_rdy;

   //--------------------------------------------------------------------------
   // Stage 1: cross products and zero check
   //--------------------------------------------------------------------------
   always_comb begin
      mul_in.wl  = PROD_W'(req_data.src_w) * PROD_W'(req_data.dst_h);
      mul_in.hl  = PROD_W'(req_data.src_h) * PROD_W'(req_data.dst_w);
      mul_in.sw  = req_data.src_w;
      mul_in.sh  = req_data.src_h;
      mul_in.dw  = req_data.dst_w;
      mul_in.dh  = req_data.dst_h;
      mul_in.bad = (req_data.src_w == '0) || (req_data.src_h == '0) ||
                   (req_data.dst_w == '0) || (req_data.dst_h == '0);
   end

   //--------------------------------------------------------------------------
   // Stage 2: pick the limiting side (tie goes to width) and set up the divide.
   // The quotient never exceeds the other target, so the high half of the
   // numerator is already below the divisor.
   //--------------------------------------------------------------------------
   always_comb begin
      logic [PROD_W-1:0] num;
      sel_in.wide = (mul_ff.wl >= mul_ff.hl);
      num         = sel_in.wide ? mul_ff.hl : mul_ff.wl;
      sel_in.den  = sel_in.wide ? mul_ff.sw : mul_ff.sh;
      sel_in.rem  = num[PROD_W-1:DIM_W];
      sel_in.low  = num[DIM_W-1:0];
      sel_in.quo  = '0;
      sel_in.dw   = mul_ff.dw;
      sel_in.dh   = mul_ff.dh;
      sel_in.bad  = mul_ff.bad;
   end

   //--------------------------------------------------------------------------
   // Divide stages
   //--------------------------------------------------------------------------
   always_comb begin
      div_in[0] = div_step(sel_ff);
      for (int d = 1; d < DIM_W; d++) begin
         div_in[d] = div_step(div_ff[d-1]);
      end
   end

   //--------------------------------------------------------------------------
   // Output stage: round half up, clamp to [1, target], centering offsets.
   // Any zero input forces all fields to zero with bad_size set.
   //--------------------------------------------------------------------------
   always_comb begin
      div_type          last;
      logic [DIM_W-1:0] thr;
      logic [DIM_W:0]   rnd;
      logic [DIM_W-1:0] tgt;
      logic [DIM_W-1:0] scl;
      logic [DIM_W-1:0] fw;
      logic [DIM_W-1:0] fh;
      logic [DIM_W-1:0] gap_x;
      logic [DIM_W-1:0] gap_y;
      last  = div_ff[DIM_W-1];
      // round up when remainder >= den - floor(den/2)
      thr   = last.den - (last.den >> 1);
      rnd   = {1'b0, last.quo} + (DIM_W+1)'(last.rem >= thr);
      tgt   = last.wide ? last.dh : last.dw;
      if (rnd == '0) begin
         scl = DIM_W'(1);
      end else if (rnd > {1'b0, tgt}) begin
         scl = tgt;
      end else begin
         scl = rnd[DIM_W-1:0];
      end
      fw    = last.wide ? last.dw : scl;
      fh    = last.wide ? scl : last.dh;
      gap_x = last.dw - fw;
      gap_y = last.dh - fh;
      if (last.bad) begin
         rsp_in = '0;
         rsp_in.bad_size = 1'b1;
      end else begin
         rsp_in.fit_w    = fw;
         rsp_in.fit_h    = fh;
         rsp_in.pad_x    = gap_x[DIM_W-1:1];
         rsp_in.pad_y    = gap_y[DIM_W-1:1];
         rsp_in.bad_size = 1'b0;
      end
   end

   //--------------------------------------------------------------------------
   // Registers: valid bits reset, payload loads with its stage
   //--------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         sel_vld_ff <= 1'b0;
         for (int d = 0; d < DIM_W; d++) begin
            div_vld_ff[d] <= 1'b0;
         end
         rsp_vld_ff <= 1'b0;
      end else begin
         if (mul_rdy) begin
            mul_vld_ff <= req_valid;
         end
         if (sel_rdy) begin
            sel_vld_ff <= mul_vld_ff;
         end
         if (div_rdy[0]) begin
            div_vld_ff[0] <= sel_vld_ff;
         end
         for (int d = 1; d < DIM_W; d++) begin
            if (div_rdy[d]) begin
               div_vld_ff[d] <= div_vld_ff[d-1];
            end
         end
         if (out_rdy) begin
            rsp_vld_ff <= div_vld_ff[DIM_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_rdy) begin
         mul_ff <= mul_in;
      end
      if (sel_rdy) begin
         sel_ff <= sel_in;
      end
      if (div_rdy[0]) begin
         div_ff[0] <= div_in[0];
      end
      for (int d = 1; d < DIM_W; d++) begin
         if (div_rdy[d]) begin
            div_ff[d] <= div_in[d];
         end
      end
      if (out_rdy) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule : letterbox_fit_geometry

`default_nettype wire

// ===== hw/rtl/lbfit_checker.sv =====
// lbfit_checker: port-level assertions for letterbox_fit_geometry, plus its bind.
// Depends on lbfit_pkg and the letterbox_fit_geometry top level.
`timescale 1ns / 1ps
`default_nettype none

module lbfit_checker
   import lbfit_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // error transactions carry all-zero geometry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_size |->
         rsp_data.fit_w == '0 && rsp_data.fit_h == '0 &&
         rsp_data.pad_x == '0 && rsp_data.pad_y == '0)
      else $error("bad_size transaction with nonzero fields");

   // good transactions never collapse a side to zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bad_size |->
         rsp_data.fit_w != '0 && rsp_data.fit_h != '0)
      else $error("fitted size of zero on a good transaction");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a stalled request holds until taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request changed");

endmodule : lbfit_checker

bind letterbox_fit_geometry lbfit_checker u_lbfit_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== bench/letterbox_fit_geometry_check.sv =====
// letterbox_fit_geometry_check: watches both channels of the fit block, predicts each
// fit from the accepted request and compares it with the response. Depends on lbfit_pkg.
`timescale 1ns / 1ps

module letterbox_fit_geometry_check
   import lbfit_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           mismatch_count,
   output int           fits_outstanding
);

   rsp_type pending_fits[$];

   initial begin
      mismatch_count   = 0;
      fits_outstanding = 0;
   end

   // (num + floor(den/2)) / den without the add overflowing
   function automatic longint unsigned div_half_up(longint unsigned num,
                                                   longint unsigned den);
      longint unsigned q;
      q = num / den;
      if (num % den >= den - den / 2) q++;
      return q;
   endfunction

   function automatic rsp_type fit_geometry(req_type r);
      longint unsigned sw, sh, dw, dh, wl, hl, fw, fh;
      rsp_type o;
      sw = r.src_w;
      sh = r.src_h;
      dw = r.dst_w;
      dh = r.dst_h;
      o  = '0;
      if (sw == 0 || sh == 0 || dw == 0 || dh == 0) begin
         o.bad_size = 1'b1;
         return o;
      end
      wl = sw * dh;
      hl = sh * dw;
      // ties go to the width side
      if (wl >= hl) begin
         fw = dw;
         fh = div_half_up(hl, sw);
         if (fh < 1) fh = 1;
      end else begin
         fh = dh;
         fw = div_half_up(wl, sh);
         if (fw < 1) fw = 1;
      end
      if (fw > dw) fw = dw;
      if (fh > dh) fh = dh;
      o.fit_w = DIM_W'(fw);
      o.fit_h = DIM_W'(fh);
      o.pad_x = PAD_W'((dw - fw) / 2);
      o.pad_y = PAD_W'((dh - fh) / 2);
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pending_fits.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_fits.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response with no request pending: fit %0dx%0d pad %0d,%0d bad %0b",
                           $realtime, rsp_data.fit_w, rsp_data.fit_h, rsp_data.pad_x,
                           rsp_data.pad_y, rsp_data.bad_size);
               mismatch_count++;
            end else begin
               want = pending_fits.pop_front();
               if (rsp_data.fit_w !== want.fit_w || rsp_data.fit_h !== want.fit_h ||
                   rsp_data.pad_x !== want.pad_x || rsp_data.pad_y !== want.pad_y ||
                   rsp_data.bad_size !== want.bad_size) begin
                  if (mismatch_count < 10) begin
                     $display("%0t: fit mismatch", $realtime);
                     $display("   expected fit %0dx%0d pad %0d,%0d bad %0b",
                              want.fit_w, want.fit_h, want.pad_x, want.pad_y, want.bad_size);
                     $display("   actual   fit %0dx%0d pad %0d,%0d bad %0b",
                              rsp_data.fit_w, rsp_data.fit_h, rsp_data.pad_x,
                              rsp_data.pad_y, rsp_data.bad_size);
                  end
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_fits.push_back(fit_geometry(req_data));
      end
      fits_outstanding = pending_fits.size();
   end

endmodule : letterbox_fit_geometry_check

// ===== bench/letterbox_fit_geometry_tb.sv =====
// letterbox_fit_geometry_tb: top of the fit block bench; drives size transactions,
// throttles the response side and reports the verdict.
// Depends on lbfit_pkg, letterbox_fit_geometry and letterbox_fit_geometry_check.
`timescale 1ns / 1ps

module letterbox_fit_geometry_tb;
   import lbfit_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int CYCLE_LIMIT  = 100000;
   // pipeline is 19 deep; wait comfortably past it at the end
   localparam int SETTLE       = 40;
   localparam int HOLD_CYCLES  = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int      mismatch_count;
   int      fits_outstanding;
   int      cycle_count = 0;

   // steady: no idling on either side; hold_req: ask the receiver for a long hold-off
   bit      steady   = 1'b0;
   bit      hold_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   letterbox_fit_geometry DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   letterbox_fit_geometry_check fit_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .mismatch_count   (mismatch_count),
      .fits_outstanding (fits_outstanding)
   );

   // Watchdog: a hung pipeline or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[letterbox_fit_geometry] ERROR");
         $finish;
      end
   end

   // Response side. Stalls at random about 13% of cycles, never while steady.
   // A hold request turns into a long stall counted here, so the pipeline backs up
   // into req_stall while the sender keeps offering.
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !steady && ($urandom_range(99) < 13);
         end
      end
   end

   // One dimension: mostly log-spread sizes, plus full range, small sizes 1 to 16 and the edges.
   function automatic logic [DIM_W-1:0] pick_dim();
      int bits;
      case ($urandom_range(9))
         0: return DIM_W'($urandom_range(0, 65535));
         1: return DIM_W'($urandom_range(1, 16));
         2: begin
            case ($urandom_range(3))
               0: return 16'd1;
               1: return 16'hFFFF;
               2: return 16'hFFFE;
               default: return 16'h8000;
            endcase
         end
         default: begin
            bits = $urandom_range(1, DIM_W);
            return DIM_W'($urandom_range(1, (1 << bits) - 1));
         end
      endcase
   endfunction

   // One size transaction: independent sizes, matched aspect ratios (exact and
   // off-by-one ties), or a zero dimension somewhere.
   function automatic req_type make_sizes();
      req_type r;
      int      a, b, s1, s2, mode;
      mode = $urandom_range(99);
      r.src_w = pick_dim();
      r.src_h = pick_dim();
      r.dst_w = pick_dim();
      r.dst_h = pick_dim();
      if (mode < 25) begin
         a  = $urandom_range(1, 64);
         b  = $urandom_range(1, 64);
         s1 = $urandom_range(1, 1023);
         s2 = $urandom_range(1, 1023);
         r.src_w = DIM_W'(a * s1);
         r.src_h = DIM_W'(b * s1);
         r.dst_w = DIM_W'(a * s2);
         r.dst_h = DIM_W'(b * s2);
         // nudge one side to land just either side of the tie
         case ($urandom_range(2))
            0: r.dst_w = r.dst_w + DIM_W'($urandom_range(0, 2)) - 16'd1;
            1: r.dst_h = r.dst_h + DIM_W'($urandom_range(0, 2)) - 16'd1;
            default: ;
         endcase
      end else if (mode < 31) begin
         case ($urandom_range(3))
            0: r.src_w = '0;
            1: r.src_h = '0;
            2: r.dst_w = '0;
            default: r.dst_h = '0;
         endcase
      end
      return r;
   endfunction

   // Offer one transaction, with an occasional idle gap first, and return at the
   // rising edge where it is taken.
   task automatic offer(input req_type item);
      int gap;
      if (!steady && $urandom_range(99) < 13) begin
         gap = $urandom_range(1, 4);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
            req_data  <= req_type'({$urandom, $urandom});
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Sender goes quiet until every outstanding fit has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (fits_outstanding != 0) @(negedge clock);
   endtask

   initial begin
      req_type corners[$];
      int      i;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero dimensions, one at a time and all together
      corners.push_back('{src_w: 16'd0,    src_h: 16'd1080, dst_w: 16'd640,  dst_h: 16'd480});
      corners.push_back('{src_w: 16'd1920, src_h: 16'd0,    dst_w: 16'd640,  dst_h: 16'd480});
      corners.push_back('{src_w: 16'd1920, src_h: 16'd1080, dst_w: 16'd0,    dst_h: 16'd480});
      corners.push_back('{src_w: 16'd1920, src_h: 16'd1080, dst_w: 16'd640,  dst_h: 16'd0});
      corners.push_back('{src_w: 16'd0,    src_h: 16'd0,    dst_w: 16'd0,    dst_h: 16'd0});
      // exact ties: width wins
      corners.push_back('{src_w: 16'hFFFF, src_h: 16'hFFFF, dst_w: 16'hFFFF, dst_h: 16'hFFFF});
      corners.push_back('{src_w: 16'd1920, src_h: 16'd1080, dst_w: 16'd1920, dst_h: 16'd1080});
      corners.push_back('{src_w: 16'd16,   src_h: 16'd9,    dst_w: 16'd32,   dst_h: 16'd18});
      corners.push_back('{src_w: 16'd1,    src_h: 16'd1,    dst_w: 16'hFFFF, dst_h: 16'hFFFF});
      corners.push_back('{src_w: 16'hFFFF, src_h: 16'hFFFF, dst_w: 16'd1,    dst_h: 16'd1});
      // width limited, then height limited
      corners.push_back('{src_w: 16'd1920, src_h: 16'd1080, dst_w: 16'd1000, dst_h: 16'd1000});
      corners.push_back('{src_w: 16'd1080, src_h: 16'd1920, dst_w: 16'd1000, dst_h: 16'd1000});
      // remainder exactly half rounds up
      corners.push_back('{src_w: 16'd2,    src_h: 16'd1,    dst_w: 16'd3,    dst_h: 16'd100});
      corners.push_back('{src_w: 16'd1,    src_h: 16'd2,    dst_w: 16'd100,  dst_h: 16'd3});
      // scaled side rounds to zero and clamps to one
      corners.push_back('{src_w: 16'hFFFF, src_h: 16'd1,    dst_w: 16'd1,    dst_h: 16'hFFFF});
      corners.push_back('{src_w: 16'd1,    src_h: 16'hFFFF, dst_w: 16'hFFFF, dst_h: 16'd1});
      // largest padding on each axis
      corners.push_back('{src_w: 16'hFFFF, src_h: 16'd1,    dst_w: 16'hFFFF, dst_h: 16'hFFFF});
      corners.push_back('{src_w: 16'd1,    src_h: 16'hFFFF, dst_w: 16'hFFFF, dst_h: 16'hFFFF});
      // alternating bit patterns
      corners.push_back('{src_w: 16'hAAAA, src_h: 16'h5555, dst_w: 16'h5555, dst_h: 16'hAAAA});
      corners.push_back('{src_w: 16'h5555, src_h: 16'hAAAA, dst_w: 16'hAAAA, dst_h: 16'h5555});

      foreach (corners[k]) offer(corners[k]);
      drain();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         // back-to-back stretch with both sides running flat out
         steady = (i >= 350 && i < 600);
         // long receiver hold-off while requests keep coming
         if (i == 800) hold_req = 1'b1;
         // sender waits for the pipeline to empty mid-run
         if (i == 1000) drain();
         offer(make_sizes());
      end

      drain();
      repeat (SETTLE) @(negedge clock);

      if (mismatch_count == 0 && fits_outstanding == 0) begin
         $display("[letterbox_fit_geometry] OK");
      end else begin
         $display("[letterbox_fit_geometry] ERROR");
      end
      $finish;
   end

endmodule : letterbox_fit_geometry_tb
